[src/bli_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_pkg
// Shared constants, types and helpers for the bounded list block.
// ----------------------------------------------------------------------------
package bli_pkg;

    localparam int CAPACITY = 32;
    localparam int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW       = $clog2(CAPACITY + 1);
    localparam int DW       = 64;

    typedef enum logic [1:0] {
        OP_INS_FRONT = 2'd0,
        OP_INS_BACK  = 2'd1,
        OP_DELETE    = 2'd2,
        OP_NOP       = 2'd3
    } t_opcode;

    // controller -> datapath
    typedef struct packed {
        logic load;   // capture the input beat
        logic apply;  // perform the list update
        logic read;   // issue one ordered read
        logic empty;  // emit the empty-list beat
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic post_empty; // list is empty after the pending update
        logic read_last;  // current read is the final entry
    } t_dp_stat;

    // circular add, both operands below CAPACITY
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
        logic [AW:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (AW + 1)'(CAPACITY)) begin
            s = s - (AW + 1)'(CAPACITY);
        end
        return s[AW-1:0];
    endfunction

endpackage

[src/bli_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_ctrl
// Sequencer: accept, update, ordered read-out of the list.
// ----------------------------------------------------------------------------
module bli_ctrl import bli_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_EXEC  = 4'b0010,
        S_READ  = 4'b0100,
        S_EMPTY = 4'b1000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.apply = 1'b1;
                n_state     = i_stat.post_empty ? S_EMPTY : S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                if (i_stat.read_last) begin
                    n_state = S_IDLE;
                end
            end
            S_EMPTY: begin
                o_cmd.empty = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

[src/bli_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_dp
// Circular entry store, head/count, read-out and delete compaction.
// ----------------------------------------------------------------------------
module bli_dp import bli_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat,
    input  logic [1:0]           i_opcode,
    input  logic signed [DW-1:0] i_data_word,
    output logic                 o_result_valid,
    output logic signed [DW-1:0] o_list_value,
    output logic                 o_is_last,
    output logic                 o_list_empty,
    output logic                 o_insert_dropped
);

    logic [DW-1:0] r_mem [CAPACITY];

    logic [AW-1:0] r_head, n_head;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_op;
    logic [DW-1:0] r_word;
    logic [AW-1:0] r_j;
    logic [AW-1:0] r_pos, n_pos;
    logic          r_del_en, n_del_en;
    logic          r_dropped, n_dropped;

    logic          r_out_vld, r_out_last, r_out_empty;
    logic [DW-1:0] r_rd_data;
    logic          r_wb_en;
    logic [AW-1:0] r_wb_addr;

    logic          ap_we;
    logic [AW-1:0] ap_addr;
    logic          full, del_ok;
    logic [AW-1:0] head_dec, src_j, rd_addr;
    logic          j_last, wb_cond;

    assign full     = (r_count == CW'(CAPACITY));
    assign head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : (r_head - 1'b1);
    assign del_ok   = (r_word[DW-1:CW] == '0) && (r_word[CW-1:0] < r_count);

    // list update for the captured item
    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_pos     = r_pos;
        n_del_en  = 1'b0;
        n_dropped = 1'b0;
        ap_we     = 1'b0;
        ap_addr   = r_head;
        case (t_opcode'(r_op))
            OP_INS_FRONT: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    n_head  = head_dec;
                    ap_we   = 1'b1;
                    ap_addr = head_dec;
                    n_count = r_count + 1'b1;
                end
            end
            OP_INS_BACK: begin
                if (full) begin
                    n_dropped = 1'b1;
                end else begin
                    ap_we   = 1'b1;
                    ap_addr = wrap_add(r_head, r_count[AW-1:0]);
                    n_count = r_count + 1'b1;
                end
            end
            OP_DELETE: begin
                if (del_ok) begin
                    n_del_en = 1'b1;
                    n_pos    = r_word[AW-1:0];
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // read-out: past the deleted slot, read one ahead and write back one down
    assign wb_cond = r_del_en && (r_j >= r_pos);
    assign src_j   = wb_cond ? (r_j + 1'b1) : r_j;
    assign rd_addr = wrap_add(r_head, src_j);
    assign j_last  = (({1'b0, r_j} + 1'b1) == (AW + 1)'(r_count));

    assign o_stat.post_empty = (n_count == '0);
    assign o_stat.read_last  = j_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
            r_wb_en   <= 1'b0;
            r_del_en  <= 1'b0;
        end else begin
            r_out_vld <= i_cmd.read | i_cmd.empty;
            r_wb_en   <= i_cmd.read & wb_cond;
            if (i_cmd.apply) begin
                r_head   <= n_head;
                r_count  <= n_count;
                r_del_en <= n_del_en;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_opcode;
            r_word <= i_data_word;
        end
        if (i_cmd.apply) begin
            r_pos     <= n_pos;
            r_dropped <= n_dropped;
            r_j       <= '0;
        end
        if (i_cmd.read) begin
            r_j        <= r_j + 1'b1;
            r_wb_addr  <= wrap_add(r_head, r_j);
            r_out_last <= j_last;
        end
        if (i_cmd.read | i_cmd.empty) begin
            r_out_empty <= i_cmd.empty;
        end
        if (i_cmd.empty) begin
            r_out_last <= 1'b1;
        end
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_wb_en && r_out_vld) begin
            r_mem[r_wb_addr] <= r_rd_data;
        end else if (i_cmd.apply && ap_we) begin
            r_mem[ap_addr] <= r_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    assign o_result_valid   = r_out_vld;
    assign o_list_value     = r_out_empty ? '0 : $signed(r_rd_data);
    assign o_is_last        = r_out_last;
    assign o_list_empty     = r_out_empty;
    assign o_insert_dropped = r_dropped;

endmodule

[src/bounded_list_insert_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_insert_delete
// Bounded ordered list of signed 64-bit values with insert/append/delete.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. After the update the
// block streams the whole list front to back, one beat per cycle on
// o_result_valid, with o_is_last on the final beat; an empty list gives one
// beat with o_list_empty set and a zero value. Beats cannot be held off, so
// the receiver must take every one in the cycle it appears. Each item takes
// one update step and then one read per entry of the updated list (one
// empty beat instead when the list ends up empty), paced by the single
// read port of the entry store. The last beat shows in the cycle busy drops,
// so a new item can be accepted alongside it. A delete is folded into the
// read-out: entries past the removed slot are read one ahead and written
// back one place down, so it costs nothing extra. Inserts into a full list
// leave it unchanged and raise o_insert_dropped on every beat of that item.
// Delete positions that are negative or not below the entry count are
// ignored. The store needs no clearing after reset: only slots below the
// entry count are ever read.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete import bli_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_opcode,
    input  logic signed [DW-1:0] i_data_word,
    output logic                 o_result_valid,
    output logic signed [DW-1:0] o_list_value,
    output logic                 o_is_last,
    output logic                 o_list_empty,
    output logic                 o_insert_dropped
);

    // controller/datapath handoff
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // sequencer: IDLE -> EXEC -> READ (N beats) or EMPTY -> IDLE
    bli_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // circular store with head pointer and entry count
    bli_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (dp_cmd),
        .o_stat           (dp_stat),
        .i_opcode         (i_opcode),
        .i_data_word      (i_data_word),
        .o_result_valid   (o_result_valid),
        .o_list_value     (o_list_value),
        .o_is_last        (o_is_last),
        .o_list_empty     (o_list_empty),
        .o_insert_dropped (o_insert_dropped)
    );

endmodule

[src/bli_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bli_checker
// Port-level checks for the bounded list block.
// ----------------------------------------------------------------------------
module bli_checker import bli_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_result_valid,
    input logic signed [DW-1:0] o_list_value,
    input logic                 o_is_last,
    input logic                 o_list_empty
);

    // an accepted beat starts work
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // empty-list beat ends the run and carries zero
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_list_empty |-> o_is_last && (o_list_value == '0))
        else $error("empty beat not last or nonzero");

    // the final beat is followed by a gap
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_is_last |=> !o_result_valid)
        else $error("beat right after last beat");

    // only the final beat may appear once the block is free
    a_mid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && !o_is_last |-> busy)
        else $error("non-final beat while idle");

endmodule

bind bounded_list_insert_delete bli_checker u_bli_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .start          (start),
    .busy           (busy),
    .o_result_valid (o_result_valid),
    .o_list_value   (o_list_value),
    .o_is_last      (o_is_last),
    .o_list_empty   (o_list_empty)
);
